// File: rtl/gamma_fade_ramp_generator_core_assert.svh
// Assertion macros for the gamma fade ramp generator checker.
`ifndef GAMMA_FADE_RAMP_GENERATOR_CORE_ASSERT_SVH
`define GAMMA_FADE_RAMP_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define GFRC_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define GFRC_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after a reset edge.
`define GFRC_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/gfr_pkg.sv
// Shared constants, types and the division step function of the gamma fade ramp generator.
`default_nettype none

package gfr_pkg;

    localparam int unsigned LEVEL_BITS = 8;
    localparam int unsigned LMAX       = (1 << LEVEL_BITS) - 1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // config register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LV_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LV_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_DUR = 3'd5;

    // pipeline depths
    localparam int unsigned TDIV_STAGES = 8;
    localparam int unsigned CDIV_STAGES = 8;
    localparam int unsigned MIX_LAT     = 4;
    localparam int unsigned CINE_LAT    = 15;
    localparam int unsigned MIX_DLY     = CINE_LAT - MIX_LAT;

    // mix path widths
    localparam int unsigned MP_W = LEVEL_BITS + 17;
    localparam int unsigned MN_W = LEVEL_BITS + 24;
    localparam int unsigned MM_W = LEVEL_BITS + 8;
    localparam int unsigned MR_W = 10;
    localparam int unsigned ME_W = MM_W + MR_W;
    localparam logic [MR_W-1:0] MIX_RECIP = MR_W'((64'd1 << MM_W) / LMAX);

    // pixel position level*65536/LMAX
    localparam int unsigned F_W  = LEVEL_BITS + 16;
    localparam int unsigned F_PW = F_W + 17;
    localparam logic [16:0] F_RECIP = 17'((64'd1 << F_W) / LMAX);

    // divide by 255 for the level lerp
    localparam logic [16:0] R255 = 17'((64'd1 << 24) / 255);

    // cinematic result select
    localparam logic [1:0] SEL_RAMP      = 2'd0;
    localparam logic [1:0] SEL_BLACK_OUT = 2'd1;
    localparam logic [1:0] SEL_WHITE_OUT = 2'd2;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  phase;
        logic                  done;
    } t_side;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [17:0] div_step(input logic [16:0] rem,
                                             input logic        nb,
                                             input logic [16:0] den);
        logic [17:0] sh;
        logic [17:0] df;
        sh = {rem, nb};
        df = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {1'b1, df[16:0]};
        end
        return {1'b0, sh[16:0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/gfr_tdiv.sv
// Fade position: pipelined elapsed/half_duration divider, clamp and phase flip.
`default_nettype none

module gfr_tdiv
    import gfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_v,
    input  logic [LEVEL_BITS-1:0] i_level,
    input  logic                  i_phase,
    input  logic [15:0]           i_elapsed,
    input  logic [15:0]           i_hd,
    output logic                  o_v,
    output t_side                 o_side,
    output logic [16:0]           o_x
);

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] quo;
    } t_tdv;

    logic [TDIV_STAGES+1:0] r_v;
    t_side                  r_sd [TDIV_STAGES+2];
    t_tdv                   r_dv [TDIV_STAGES+1];
    logic [16:0]            r_x;
    logic [16:0]            w_t;
    logic [16:0]            w_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[TDIV_STAGES:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= '{level: i_level, phase: i_phase, done: (i_elapsed >= i_hd)};
            for (int k = 1; k < TDIV_STAGES + 2; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_dv[0] <= '{rem: {1'b0, i_elapsed}, quo: '0};
            r_x     <= w_x;
        end
    end

    // two quotient bits per stage
    for (genvar k = 1; k <= TDIV_STAGES; k++) begin : g_st
        logic [17:0] w_a;
        logic [17:0] w_b;
        always_comb begin
            w_a = div_step(r_dv[k-1].rem, 1'b0, {1'b0, i_hd});
            w_b = div_step(w_a[16:0], 1'b0, {1'b0, i_hd});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k] <= '{rem: w_b[16:0], quo: {r_dv[k-1].quo[13:0], w_a[17], w_b[17]}};
            end
        end
    end

    // elapsed at or past half_duration saturates t to one
    always_comb begin
        w_t = r_sd[TDIV_STAGES].done ? ONE_Q16 : {1'b0, r_dv[TDIV_STAGES].quo};
        w_x = r_sd[TDIV_STAGES].phase ? (ONE_Q16 - w_t) : w_t;
    end

    assign o_v    = r_v[TDIV_STAGES+1];
    assign o_side = r_sd[TDIV_STAGES+1];
    assign o_x    = r_x;

endmodule

`default_nettype wire

// File: rtl/gfr_shape.sv
// Fade curve: linear pass or two-stage smoothstep x*x*(3-2x).
`default_nettype none

module gfr_shape
    import gfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_v,
    input  t_side       i_side,
    input  logic [16:0] i_x,
    input  logic        i_curve,
    output logic        o_v,
    output t_side       o_side,
    output logic [16:0] o_s
);

    logic [1:0]  r_v;
    t_side       r_sd [2];
    logic [16:0] r_q;
    logic [16:0] r_xa;
    logic [16:0] r_s;
    logic [33:0] w_sq;
    logic [17:0] w_fac;
    logic [34:0] w_prod;
    logic [16:0] w_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_v};
        end
    end

    always_comb begin
        w_sq   = 34'(i_x) * 34'(i_x);
        w_fac  = 18'(196608) - {r_xa, 1'b0};
        w_prod = 35'(r_q) * 35'(w_fac);
        if (!i_curve) begin
            w_s = r_xa;
        end else if (w_prod[34:16] > 19'(ONE_Q16)) begin
            w_s = ONE_Q16;
        end else begin
            w_s = w_prod[32:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            r_sd[1] <= r_sd[0];
            r_q     <= w_sq[32:16];
            r_xa    <= i_x;
            r_s     <= w_s;
        end
    end

    assign o_v    = r_v[1];
    assign o_side = r_sd[1];
    assign o_s    = r_s;

endmodule

`default_nettype wire

// File: rtl/gfr_mix.sv
// Mix mode: per-channel truncated lerp from the level toward the target colour.
`default_nettype none

module gfr_mix
    import gfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [LEVEL_BITS-1:0] i_level,
    input  logic [16:0]           i_s,
    input  logic [23:0]           i_color,
    output t_rgb                  o_rgb
);

    logic [MP_W-1:0] r1_p1;
    logic [24:0]     r1_p2 [3];
    logic [MM_W-1:0] r2_m  [3];
    logic [MM_W-1:0] r3_m  [3];
    logic [7:0]      r3_e  [3];
    t_rgb            r4_rgb;

    logic [MN_W-1:0] w_n   [3];
    logic [ME_W-1:0] w_pr  [3];
    logic [MM_W-1:0] w_rem [3];
    logic [7:0]      w_ch  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n[i]   = MN_W'(r1_p1) * MN_W'(255) + MN_W'(r1_p2[i]) * MN_W'(LMAX);
            w_pr[i]  = ME_W'(r2_m[i]) * ME_W'(MIX_RECIP);
            w_rem[i] = r3_m[i] - MM_W'(MM_W'(r3_e[i]) * MM_W'(LMAX));
            w_ch[i]  = r3_e[i] + 8'(w_rem[i] >= MM_W'(LMAX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p1 <= MP_W'(i_level) * MP_W'(ONE_Q16 - i_s);
            for (int i = 0; i < 3; i++) begin
                r1_p2[i] <= 25'(i_color[8*(2-i) +: 8]) * 25'(i_s);
                r2_m[i]  <= w_n[i][MN_W-1:16];
                r3_m[i]  <= r2_m[i];
                // reciprocal estimate, at most one low
                r3_e[i]  <= w_pr[i][MM_W+7:MM_W];
            end
            r4_rgb <= '{red: w_ch[0], green: w_ch[1], blue: w_ch[2]};
        end
    end

    assign o_rgb = r4_rgb;

endmodule

`default_nettype wire

// File: rtl/gfr_cine.sv
// Cinematic mode: level lerp, input clamp, pipelined remap divider, grey out.
`default_nettype none

module gfr_cine
    import gfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_v,
    input  t_side       i_side,
    input  logic [16:0] i_s,
    input  logic [31:0] i_lv_start,
    input  logic [31:0] i_lv_end,
    output logic        o_v,
    output t_side       o_side,
    output logic [7:0]  o_grey
);

    typedef struct packed {
        logic [16:0] rem;
        logic [16:0] quo;
        logic [15:0] nlo;
        logic [16:0] dd;
        logic [16:0] bo;
        logic [16:0] wo;
        logic [1:0]  sel;
    } t_cdv;

    logic [CINE_LAT-1:0] r_v;
    t_side               r_sd [CINE_LAT];

    logic [24:0] r1_p  [4];
    logic [16:0] r1_fe;
    logic [24:0] r2_p  [4];
    logic [16:0] r2_le [4];
    logic [16:0] r2_f;
    logic [16:0] r3_l  [4];
    logic [16:0] r3_f;
    logic [16:0] r4_dn, r4_dw, r4_dd, r4_bo, r4_wo;
    logic [1:0]  r4_sel;
    logic [33:0] r5_n;
    logic [16:0] r5_dd, r5_bo, r5_wo;
    logic [1:0]  r5_sel;
    t_cdv        r_dv [CDIV_STAGES+1];
    logic [7:0]  r_grey;

    logic [F_W-1:0]  w_fn1, w_fn2;
    logic [F_PW-1:0] w_fprod;
    logic [F_W:0]    w_frem;
    logic [40:0]     w_lprod [4];
    logic [24:0]     w_lrem  [4];
    logic [16:0]     w_fc;
    logic [1:0]      w_sel;
    logic [17:0]     w_d6;
    logic [17:0]     w_g;
    logic [16:0]     w_gc;
    logic [24:0]     w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[CINE_LAT-2:0], i_v};
        end
    end

    always_comb begin
        w_fn1   = {i_side.level, 16'h0000};
        w_fprod = F_PW'(w_fn1) * F_PW'(F_RECIP);
        w_fn2   = {r_sd[0].level, 16'h0000};
        w_frem  = (F_W+1)'(w_fn2) - (F_W+1)'((F_W+1)'(r1_fe) * (F_W+1)'(LMAX));
        for (int i = 0; i < 4; i++) begin
            w_lprod[i] = 41'(r1_p[i]) * 41'(R255);
            w_lrem[i]  = r2_p[i] - 25'(25'(r2_le[i]) * 25'(255));
        end
        // black_in 0, white_in 1, black_out 2, white_out 3
        w_fc = (r3_f < r3_l[0]) ? r3_l[0] : r3_f;
        w_fc = (w_fc > r3_l[1]) ? r3_l[1] : w_fc;
        if (r3_l[1] <= r3_l[0]) begin
            w_sel = SEL_BLACK_OUT;
        end else if (r3_l[3] < r3_l[2]) begin
            w_sel = SEL_WHITE_OUT;
        end else begin
            w_sel = SEL_RAMP;
        end
        w_d6 = div_step(r5_n[33:17], r5_n[16], r5_dd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int k = 1; k < CINE_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            for (int i = 0; i < 4; i++) begin
                r1_p[i]  <= 25'(i_lv_start[8*i +: 8]) * 25'(ONE_Q16 - i_s)
                          + 25'(i_lv_end[8*i +: 8]) * 25'(i_s);
                r2_p[i]  <= r1_p[i];
                r2_le[i] <= w_lprod[i][40:24];
                r3_l[i]  <= r2_le[i] + 17'(w_lrem[i] >= 25'(255));
            end
            r1_fe  <= w_fprod[F_PW-1:F_W];
            r2_f   <= r1_fe + 17'(w_frem >= (F_W+1)'(LMAX));
            r3_f   <= r2_f;
            r4_dn  <= w_fc - r3_l[0];
            r4_dw  <= r3_l[3] - r3_l[2];
            r4_dd  <= r3_l[1] - r3_l[0];
            r4_bo  <= r3_l[2];
            r4_wo  <= r3_l[3];
            r4_sel <= w_sel;
            r5_n   <= 34'(r4_dn) * 34'(r4_dw);
            r5_dd  <= r4_dd;
            r5_bo  <= r4_bo;
            r5_wo  <= r4_wo;
            r5_sel <= r4_sel;
            r_dv[0] <= '{rem: w_d6[16:0], quo: {16'h0000, w_d6[17]}, nlo: r5_n[15:0],
                         dd: r5_dd, bo: r5_bo, wo: r5_wo, sel: r5_sel};
            r_grey <= w_out[23:16];
        end
    end

    // remap divider, two quotient bits per stage
    for (genvar k = 1; k <= CDIV_STAGES; k++) begin : g_st
        logic [17:0] w_a;
        logic [17:0] w_b;
        always_comb begin
            w_a = div_step(r_dv[k-1].rem, r_dv[k-1].nlo[15], r_dv[k-1].dd);
            w_b = div_step(w_a[16:0], r_dv[k-1].nlo[14], r_dv[k-1].dd);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k] <= '{rem: w_b[16:0],
                             quo: {r_dv[k-1].quo[14:0], w_a[17], w_b[17]},
                             nlo: {r_dv[k-1].nlo[13:0], 2'b00},
                             dd:  r_dv[k-1].dd,
                             bo:  r_dv[k-1].bo,
                             wo:  r_dv[k-1].wo,
                             sel: r_dv[k-1].sel};
            end
        end
    end

    always_comb begin
        w_g = {1'b0, r_dv[CDIV_STAGES].bo} + {1'b0, r_dv[CDIV_STAGES].quo};
        case (r_dv[CDIV_STAGES].sel)
            SEL_BLACK_OUT: w_gc = r_dv[CDIV_STAGES].bo;
            SEL_WHITE_OUT: w_gc = r_dv[CDIV_STAGES].wo;
            default: begin
                w_gc = (w_g > {1'b0, r_dv[CDIV_STAGES].wo}) ? r_dv[CDIV_STAGES].wo
                                                            : w_g[16:0];
            end
        endcase
        w_out = 25'(w_gc) * 25'(255);
    end

    assign o_v    = r_v[CINE_LAT-1];
    assign o_side = r_sd[CINE_LAT-1];
    assign o_grey = r_grey;

endmodule

`default_nettype wire

// File: rtl/gamma_fade_ramp_generator_core.sv
// Gamma fade ramp generator core: top level with config registers and output skid.
//
// One ramp level plus fade elapsed time and phase goes in, one RGB ramp entry and a
// phase-done flag come out. The core takes one word per clock and keeps doing so
// while a result waits: a two-entry output stage (output register plus skid) lets
// the pipeline run until both are full, and only then is o_stall raised. Each
// accepted input word travels to o_valid through 10 stages for the fade position
// (capture, an 8-stage radix-4 restoring divider for elapsed/half_duration, and the
// clamp/phase flip), 2 stages of smoothstep shaping, 15 stages for the cinematic
// levels path (level lerp and divide by 255, clamp, a 17x17 multiply and a 9-stage
// restoring divider for the output remap), and the output register. The mix path is
// 4 stages and is delayed to line up with the cinematic path; mode picks one at the
// end. Configuration writes take effect at once and should only be made when the
// core is idle. half_duration of zero makes t one and sets done.
`default_nettype none

module gamma_fade_ramp_generator_core
    import gfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    // input word
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LEVEL_BITS-1:0] i_level,
    input  logic [15:0]           i_elapsed,
    input  logic                  i_phase,
    // output word
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_done_res
);

    // config registers
    logic        r_mode;
    logic        r_curve;
    logic [23:0] r_target;
    logic [31:0] r_lv_start;
    logic [31:0] r_lv_end;
    logic [15:0] r_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_curve    <= 1'b0;
            r_target   <= '0;
            r_lv_start <= 32'hFF00FF00;
            r_lv_end   <= 32'hFF00FF00;
            r_hd       <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                CFG_CURVE:    r_curve    <= i_cfg_data[0];
                CFG_TARGET:   r_target   <= i_cfg_data[23:0];
                CFG_LV_START: r_lv_start <= i_cfg_data;
                CFG_LV_END:   r_lv_end   <= i_cfg_data;
                CFG_HALF_DUR: r_hd       <= i_cfg_data[15:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // pipeline advances whenever the skid entry is free
    logic        w_en;
    logic        r_ov;
    logic        r_skv;
    logic        w_take;

    assign w_en    = !r_skv;
    assign w_take  = r_ov && !i_stall;
    assign o_stall = r_skv;

    // fade position
    logic        w_tv;
    t_side       w_tside;
    logic [16:0] w_x;

    gfr_tdiv u_tdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_v       (i_valid),
        .i_level   (i_level),
        .i_phase   (i_phase),
        .i_elapsed (i_elapsed),
        .i_hd      (r_hd),
        .o_v       (w_tv),
        .o_side    (w_tside),
        .o_x       (w_x)
    );

    // curve shaping
    logic        w_sv;
    t_side       w_sside;
    logic [16:0] w_s;

    gfr_shape u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (w_tv),
        .i_side  (w_tside),
        .i_x     (w_x),
        .i_curve (r_curve),
        .o_v     (w_sv),
        .o_side  (w_sside),
        .o_s     (w_s)
    );

    // mix path, then delay to cinematic latency
    t_rgb w_mix;
    t_rgb r_mixd [MIX_DLY];

    gfr_mix u_mix (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_level (w_sside.level),
        .i_s     (w_s),
        .i_color (r_target),
        .o_rgb   (w_mix)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mixd[0] <= w_mix;
            for (int k = 1; k < MIX_DLY; k++) begin
                r_mixd[k] <= r_mixd[k-1];
            end
        end
    end

    // cinematic path carries the valid and side info to the end
    logic       w_pv;
    t_side      w_pside;
    logic [7:0] w_grey;

    gfr_cine u_cine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_v        (w_sv),
        .i_side     (w_sside),
        .i_s        (w_s),
        .i_lv_start (r_lv_start),
        .i_lv_end   (r_lv_end),
        .o_v        (w_pv),
        .o_side     (w_pside),
        .o_grey     (w_grey)
    );

    t_rgb w_res;
    assign w_res = r_mode ? '{red: w_grey, green: w_grey, blue: w_grey}
                          : r_mixd[MIX_DLY-1];

    // output register plus skid entry
    t_rgb r_out;
    logic r_od;
    t_rgb r_sk;
    logic r_skd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (w_take) begin
                r_skv <= 1'b0;
            end
        end else if (w_pv) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_skv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skv) begin
            if (w_take) begin
                r_out <= r_sk;
                r_od  <= r_skd;
            end
        end else if (w_pv) begin
            if (!r_ov || w_take) begin
                r_out <= w_res;
                r_od  <= w_pside.done;
            end else begin
                r_sk  <= w_res;
                r_skd <= w_pside.done;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_red      = r_out.red;
    assign o_green    = r_out.green;
    assign o_blue     = r_out.blue;
    assign o_done_res = r_od;

endmodule

`default_nettype wire

// File: rtl/gfr_chk.sv
// Port-level checker for the gamma fade ramp generator, bound to the top level.
`default_nettype none

`include "gamma_fade_ramp_generator_core_assert.svh"

module gfr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_done_res
);

    `GFRC_RESET(a_reset_clears, !o_valid && !o_stall, "output stage not empty after reset")

    `GFRC_SAME(a_stall_needs_word, o_stall, o_valid, "input stalled with no output word")

    `GFRC_NEXT(a_take_frees_input, o_valid && !i_stall, !o_stall, "input stalled after a take")

    `GFRC_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_done_res), "stalled output word changed")

endmodule

bind gamma_fade_ramp_generator_core gfr_chk u_gfr_chk (.*);

`default_nettype wire
